>>> rtl/tcw_pkg.sv
// text console writer package
// request and response word types and character codes, no dependencies
package tcw_pkg;

	localparam logic REQ_PUT  = 1'b0;
	localparam logic REQ_READ = 1'b1;

	localparam logic [7:0] CH_NEWLINE   = 8'd10;
	localparam logic [7:0] CH_BACKSPACE = 8'd8;
	localparam logic [7:0] CH_SPACE     = 8'd32;

	typedef struct packed {
		logic       req_type;
		logic [7:0] char_code;
		logic [7:0] color;
		logic [4:0] read_row;
		logic [6:0] read_col;
	} req_word_t;

	typedef struct packed {
		logic [15:0] cell_value;
		logic [4:0]  cursor_row;
		logic [6:0]  cursor_col;
		logic        scrolled;
	} rsp_word_t;

endpackage

>>> rtl/tcw_screen_mem.sv
// screen store: one write port, one read port, registered read data
// no package dependencies
module tcw_screen_mem #(
	parameter int DEPTH = 2000,
	parameter int AW    = 11
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [15:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [15:0]   rdata
);

	logic [15:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/tcw_engine.sv
// request sequencer: cursor, scroll base row, clearing pass and row fill
// uses tcw_pkg; drives the ports of tcw_screen_mem
module tcw_engine import tcw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25,
	parameter int AW      = 11
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  req_word_t     req,
	input  logic          res_free,
	output logic          res_valid,
	output rsp_word_t     res,
	output logic          mem_we,
	output logic [AW-1:0] mem_waddr,
	output logic [15:0]   mem_wdata,
	output logic          mem_re,
	output logic [AW-1:0] mem_raddr,
	input  logic [15:0]   mem_rdata
);

	localparam int RW    = $clog2(ROWS);
	localparam int CW    = $clog2(COLUMNS);
	localparam int CELLS = ROWS * COLUMNS;
	localparam logic [RW:0]   ROWS_P   = (RW+1)'(ROWS);
	localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);
	localparam logic [CW-1:0] COL_LAST = CW'(COLUMNS - 1);
	localparam logic [AW-1:0] CELL_LAST = AW'(CELLS - 1);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC,
		S_RDWAIT,
		S_FILL,
		S_DONE
	} state_t;

	state_t          state_q;
	req_word_t       in_q;
	logic [RW-1:0]   row_q;
	logic [CW-1:0]   col_q;
	logic [RW-1:0]   base_q;
	logic [AW-1:0]   clr_q;
	logic [AW-1:0]   fill_addr_q;
	logic [CW-1:0]   fill_col_q;
	logic [15:0]     cell_q;
	logic            scrolled_q;

	logic            is_put;
	logic            is_nl;
	logic            is_bs;
	logic            in_range;
	logic            adv_row;
	logic [CW-1:0]   col_next;

	function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] base,
			input logic [RW-1:0] r, input logic [CW-1:0] c);
		logic [RW:0] p;
		p = {1'b0, base} + {1'b0, r};
		if (p >= ROWS_P) begin
			p = p - ROWS_P;
		end
		return AW'(p) * AW'(COLUMNS) + AW'(c);
	endfunction

	assign is_put   = (in_q.req_type == REQ_PUT);
	assign is_nl    = (in_q.char_code == CH_NEWLINE);
	assign is_bs    = (in_q.char_code == CH_BACKSPACE);
	assign in_range = (32'(in_q.read_row) < 32'(ROWS)) && (32'(in_q.read_col) < 32'(COLUMNS));

	always_comb begin
		adv_row  = 1'b0;
		col_next = col_q;
		if (is_nl) begin
			col_next = '0;
			adv_row  = 1'b1;
		end else if (is_bs) begin
			if (col_q != '0) begin
				col_next = col_q - 1'b1;
			end
		end else if (col_q == COL_LAST) begin
			col_next = '0;
			adv_row  = 1'b1;
		end else begin
			col_next = col_q + 1'b1;
		end
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cell_addr(base_q, row_q, col_q);
		mem_wdata = {in_q.color, in_q.char_code};
		mem_re    = 1'b0;
		mem_raddr = cell_addr(base_q, RW'(in_q.read_row), CW'(in_q.read_col));
		case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			S_EXEC: begin
				if (!is_put) begin
					mem_re = in_range;
				end else if (is_bs) begin
					mem_we    = (col_q != '0);
					mem_waddr = cell_addr(base_q, row_q, col_q - 1'b1);
					mem_wdata = {in_q.color, CH_SPACE};
				end else if (!is_nl) begin
					mem_we = 1'b1;
				end
			end
			S_FILL: begin
				mem_we    = 1'b1;
				mem_waddr = fill_addr_q;
				mem_wdata = {in_q.color, CH_SPACE};
			end
			default: begin
			end
		endcase
	end

	assign req_stall = (state_q != S_IDLE);
	assign res_valid = (state_q == S_DONE) && res_free;
	assign res       = '{cell_value: cell_q, cursor_row: 5'(row_q), cursor_col: 7'(col_q),
		scrolled: scrolled_q};

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid) begin
			in_q <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			row_q       <= '0;
			col_q       <= '0;
			base_q      <= '0;
			clr_q       <= '0;
			fill_addr_q <= '0;
			fill_col_q  <= '0;
			cell_q      <= '0;
			scrolled_q  <= 1'b0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CELL_LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						cell_q     <= '0;
						scrolled_q <= 1'b0;
						state_q    <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (!is_put) begin
						state_q <= in_range ? S_RDWAIT : S_DONE;
					end else begin
						col_q   <= col_next;
						state_q <= S_DONE;
						if (adv_row) begin
							if (row_q == ROW_LAST) begin
								// old top row becomes the new bottom row
								fill_addr_q <= AW'(base_q) * AW'(COLUMNS);
								fill_col_q  <= '0;
								base_q      <= (base_q == ROW_LAST) ? '0 : base_q + 1'b1;
								scrolled_q  <= 1'b1;
								state_q     <= S_FILL;
							end else begin
								row_q <= row_q + 1'b1;
							end
						end
					end
				end
				S_RDWAIT: begin
					cell_q  <= mem_rdata;
					state_q <= S_DONE;
				end
				S_FILL: begin
					fill_addr_q <= fill_addr_q + 1'b1;
					fill_col_q  <= fill_col_q + 1'b1;
					if (fill_col_q == COL_LAST) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/text_console_writer.sv
// text console writer top level: sequencer, screen store, response register
// uses tcw_pkg, tcw_engine and tcw_screen_mem
//
//  channel | word         | handshake
//  req     | req_word_t   | req_valid in, req_stall out
//  rsp     | rsp_word_t   | rsp_valid out, rsp_stall in
//
// put: S_EXEC then S_DONE; read adds S_RDWAIT; a put that scrolls adds a row fill in S_FILL
// scroll moves a base row pointer, then the new bottom row is filled with spaces
// after reset a clearing pass writes every cell, req_stall held high
// one word is worked on at a time; a finished word waits in the response register
// and the next request is taken while it is stalled there
module text_console_writer import tcw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_word_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_word_t rsp
);

	localparam int CELLS = ROWS * COLUMNS;
	localparam int AW    = $clog2(CELLS);

	logic          res_free;
	logic          res_valid;
	rsp_word_t     res;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [15:0]   mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic [15:0]   mem_rdata;
	logic          rsp_valid_q;
	rsp_word_t     rsp_q;

	tcw_engine #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS),
		.AW     (AW)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.res_free (res_free),
		.res_valid(res_valid),
		.res      (res),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_re   (mem_re),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	tcw_screen_mem #(
		.DEPTH(CELLS),
		.AW   (AW)
	) u_screen_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign res_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			rsp_q <= res;
		end
	end

endmodule
